// ===== design/c3f_pkg.sv =====
`timescale 1ns / 1ps
// c3f_pkg: shared constants, types and codes of the 3x3 mod-256 filter core.
// No dependencies; every other file of the core refers to it by scoped names.

package c3f_pkg;

    // Frame geometry limits
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;

    // Width of the geometry fields on the configuration port
    localparam int CFG_GEOM_W = 11;
    localparam int CFG_DATA_W = 64;
    localparam int CFG_IDX_W  = 2;

    // Power-on geometry (before clamping to the limits)
    localparam int FRAME_W_RESET = 1024;
    localparam int FRAME_H_RESET = 1024;

    // Counter widths: a column index, and widths/rows that may reach the limit itself
    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int W_W   = $clog2(MAX_WIDTH) + 1;
    localparam int H_W   = $clog2(MAX_HEIGHT) + 1;

    // Line store: four row banks, picked by the low bits of the row number
    localparam int LINE_ROWS = 4;
    localparam int BANK_W    = 2;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH) + 1;

    localparam int KERNEL_TAPS = 9;
    localparam int KERNEL_DIM  = 3;

    // Input command codes
    typedef enum logic {
        CMD_PIXEL = 1'b0,
        CMD_DRAIN = 1'b1
    } t_cmd;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_WIDTH  = 2'd0,
        REG_FRAME_HEIGHT = 2'd1,
        REG_KERNEL_LOW   = 2'd2,
        REG_KERNEL_NINTH = 2'd3
    } t_cfg_reg;

    typedef logic [7:0] t_pix;

    // One window column, index 0 = top row, 2 = bottom row
    typedef t_pix [KERNEL_DIM-1:0] t_col;

    // 3x3 window, index 0 = left column, 2 = right column
    typedef t_col [KERNEL_DIM-1:0] t_win;

    // Kernel: byte k is tap 3*row + col
    typedef t_pix [KERNEL_TAPS-1:0] t_kernel;

    // Effective (clamped) frame geometry
    typedef struct packed {
        logic [W_W-1:0] width;
        logic [H_W-1:0] height;
    } t_geom;

    // One beat handed from front to back
    typedef struct packed {
        t_win window;
        logic last;
    } t_item;

endpackage

// ===== design/c3f_queue.sv =====
`timescale 1ns / 1ps
// c3f_queue: small FIFO of window beats between the front and the back.
// Depends on c3f_pkg.

module c3f_queue (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_push,
    input  c3f_pkg::t_item              i_item,
    input  logic                        i_pop,
    output c3f_pkg::t_item              o_item,
    output logic                        o_empty,
    output logic [c3f_pkg::QCNT_W-1:0]  o_count
);

    c3f_pkg::t_item                 r_slot [c3f_pkg::QUEUE_DEPTH];
    logic [c3f_pkg::QPTR_W-1:0]     r_wptr;
    logic [c3f_pkg::QPTR_W-1:0]     r_rptr;
    logic [c3f_pkg::QCNT_W-1:0]     r_count;
    logic                           do_pop;

    assign o_empty = (r_count == '0);
    assign o_count = r_count;
    assign o_item  = r_slot[r_rptr];
    assign do_pop  = i_pop && !o_empty;

    // Storage, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wptr] <= i_item;
        end
    end

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (i_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && do_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ===== design/c3f_front.sv =====
`timescale 1ns / 1ps
// c3f_front: input side of the filter: raster counters, line store banks,
// emission decision and 3x3 window assembly. Depends on c3f_pkg.

module c3f_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_restart,
    input  c3f_pkg::t_geom              i_geom,
    input  logic                        i_push,
    input  logic                        i_command,
    input  logic [7:0]                  i_pixel,
    input  logic [c3f_pkg::QCNT_W-1:0]  i_q_count,
    output logic                        o_full,
    output logic                        o_q_push,
    output c3f_pkg::t_item              o_q_item
);

    // Raster counters
    logic [c3f_pkg::H_W-1:0]    r_in_row;
    logic [c3f_pkg::COL_W-1:0]  r_in_col;
    logic [c3f_pkg::H_W-1:0]    r_out_row;
    logic [c3f_pkg::COL_W-1:0]  r_out_col;

    logic                       accept;
    logic                       wr_en;
    logic                       emit;
    logic                       last;
    logic [c3f_pkg::H_W-1:0]    n_in_row;
    logic [c3f_pkg::COL_W-1:0]  n_in_col;
    logic [c3f_pkg::W_W-1:0]    in_col_p1;
    logic [c3f_pkg::H_W-1:0]    out_row_p1;
    logic [c3f_pkg::W_W-1:0]    out_col_p1;
    logic [c3f_pkg::H_W-1:0]    ri;
    logic [c3f_pkg::W_W-1:0]    rj;
    logic [c3f_pkg::H_W-1:0]    h_m1;
    logic [c3f_pkg::W_W-1:0]    w_m1;
    logic [c3f_pkg::COL_W-1:0]  addr_a;
    logic [c3f_pkg::BANK_W-1:0] wr_bank;

    // Bank read data, port A = column right of the output, port B = output column
    c3f_pkg::t_pix              r_rd_a [c3f_pkg::LINE_ROWS];
    c3f_pkg::t_pix              r_rd_b [c3f_pkg::LINE_ROWS];

    // Window-build stage
    logic                       r_f1_valid;
    logic                       r_f1_start;
    logic                       r_f1_a_ok;
    logic                       r_f1_top_ok;
    logic                       r_f1_bot_ok;
    logic [c3f_pkg::BANK_W-1:0] r_f1_rsel;
    logic                       r_f1_last;
    logic                       r_f1_fwd_a;
    logic                       r_f1_fwd_b;
    logic [c3f_pkg::BANK_W-1:0] r_f1_fwd_bank;
    c3f_pkg::t_pix              r_f1_fwd_pix;

    c3f_pkg::t_win              r_window;
    c3f_pkg::t_win              n_window;
    c3f_pkg::t_pix              dat_a [c3f_pkg::LINE_ROWS];
    c3f_pkg::t_pix              dat_b [c3f_pkg::LINE_ROWS];
    c3f_pkg::t_col              col_a;
    c3f_pkg::t_col              col_b;
    logic [c3f_pkg::BANK_W-1:0] bank_top;
    logic [c3f_pkg::BANK_W-1:0] bank_mid;
    logic [c3f_pkg::BANK_W-1:0] bank_bot;

    // Hold off input while the queue could not take every beat in flight
    assign o_full = (i_q_count + c3f_pkg::QCNT_W'(r_f1_valid))
                    >= c3f_pkg::QCNT_W'(c3f_pkg::QUEUE_DEPTH);
    assign accept = i_push && !o_full;

    // Input position update, readiness of the next result
    always_comb begin
        w_m1       = i_geom.width - 1'b1;
        h_m1       = i_geom.height - 1'b1;
        wr_en      = accept && (i_command == c3f_pkg::CMD_PIXEL)
                     && (r_in_row < i_geom.height);
        wr_bank    = r_in_row[c3f_pkg::BANK_W-1:0];
        in_col_p1  = c3f_pkg::W_W'(r_in_col) + 1'b1;
        n_in_row   = r_in_row;
        n_in_col   = r_in_col;
        if (wr_en) begin
            if (in_col_p1 >= i_geom.width) begin
                n_in_col = '0;
                n_in_row = r_in_row + 1'b1;
            end else begin
                n_in_col = c3f_pkg::COL_W'(in_col_p1);
            end
        end
        // Bottom-right in-frame neighbor of the next result
        out_row_p1 = r_out_row + 1'b1;
        out_col_p1 = c3f_pkg::W_W'(r_out_col) + 1'b1;
        ri         = (out_row_p1 < i_geom.height) ? out_row_p1 : h_m1;
        rj         = (out_col_p1 < i_geom.width) ? out_col_p1 : w_m1;
        emit       = accept && ((n_in_row >= i_geom.height) || (ri < n_in_row)
                     || ((ri == n_in_row) && (rj < c3f_pkg::W_W'(n_in_col))));
        last       = (r_out_row == h_m1) && (c3f_pkg::W_W'(r_out_col) == w_m1);
        addr_a     = c3f_pkg::COL_W'(out_col_p1);
    end

    // Counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_restart) begin
            r_in_row  <= '0;
            r_in_col  <= '0;
            r_out_row <= '0;
            r_out_col <= '0;
        end else if (emit && last) begin
            // Frame done, next frame starts
            r_in_row  <= '0;
            r_in_col  <= '0;
            r_out_row <= '0;
            r_out_col <= '0;
        end else begin
            r_in_row <= n_in_row;
            r_in_col <= n_in_col;
            if (emit) begin
                if (out_col_p1 >= i_geom.width) begin
                    r_out_col <= '0;
                    r_out_row <= out_row_p1;
                end else begin
                    r_out_col <= c3f_pkg::COL_W'(out_col_p1);
                end
            end
        end
    end

    // Line store: one bank per row modulo four, one write and two reads each
    for (genvar b = 0; b < c3f_pkg::LINE_ROWS; b++) begin : g_bank
        c3f_pkg::t_pix r_mem [c3f_pkg::MAX_WIDTH];

        always_ff @(posedge i_clk) begin
            if (wr_en && (wr_bank == c3f_pkg::BANK_W'(b))) begin
                r_mem[r_in_col] <= i_pixel;
            end
            r_rd_a[b] <= r_mem[addr_a];
            r_rd_b[b] <= r_mem[r_out_col];
        end
    end

    // Window-build stage valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_valid <= 1'b0;
        end else begin
            r_f1_valid <= emit;
        end
    end

    // Window-build stage payload: masks, bank select, bypass of this beat's pixel
    always_ff @(posedge i_clk) begin
        r_f1_start    <= (r_out_col == '0);
        r_f1_a_ok     <= (out_col_p1 < i_geom.width);
        r_f1_top_ok   <= (r_out_row != '0);
        r_f1_bot_ok   <= (out_row_p1 < i_geom.height);
        r_f1_rsel     <= r_out_row[c3f_pkg::BANK_W-1:0];
        r_f1_last     <= last;
        r_f1_fwd_a    <= wr_en && (r_in_col == addr_a);
        r_f1_fwd_b    <= wr_en && (r_in_col == r_out_col);
        r_f1_fwd_bank <= wr_bank;
        r_f1_fwd_pix  <= i_pixel;
    end

    // Assemble the new columns, zero outside the frame, shift the window
    always_comb begin
        for (int b = 0; b < c3f_pkg::LINE_ROWS; b++) begin
            dat_a[b] = (r_f1_fwd_a && (r_f1_fwd_bank == c3f_pkg::BANK_W'(b)))
                       ? r_f1_fwd_pix : r_rd_a[b];
            dat_b[b] = (r_f1_fwd_b && (r_f1_fwd_bank == c3f_pkg::BANK_W'(b)))
                       ? r_f1_fwd_pix : r_rd_b[b];
        end
        bank_mid = r_f1_rsel;
        bank_top = r_f1_rsel - 1'b1;
        bank_bot = r_f1_rsel + 1'b1;

        col_a[0] = (r_f1_a_ok && r_f1_top_ok) ? dat_a[bank_top] : '0;
        col_a[1] = r_f1_a_ok ? dat_a[bank_mid] : '0;
        col_a[2] = (r_f1_a_ok && r_f1_bot_ok) ? dat_a[bank_bot] : '0;

        col_b[0] = r_f1_top_ok ? dat_b[bank_top] : '0;
        col_b[1] = dat_b[bank_mid];
        col_b[2] = r_f1_bot_ok ? dat_b[bank_bot] : '0;

        if (r_f1_start) begin
            n_window[0] = '0;
            n_window[1] = col_b;
            n_window[2] = col_a;
        end else begin
            n_window[0] = r_window[1];
            n_window[1] = r_window[2];
            n_window[2] = col_a;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_f1_valid) begin
            r_window <= n_window;
        end
    end

    assign o_q_push        = r_f1_valid;
    assign o_q_item.window = n_window;
    assign o_q_item.last   = r_f1_last;

endmodule

// ===== design/c3f_back.sv =====
`timescale 1ns / 1ps
// c3f_back: result side of the filter: nine tap products, modulo-256 sum and
// a two-entry output buffer. Depends on c3f_pkg.

module c3f_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  c3f_pkg::t_item      i_item,
    input  logic                i_q_empty,
    output logic                o_q_pop,
    input  c3f_pkg::t_kernel    i_kernel,
    input  logic                i_pop,
    output logic                o_empty,
    output logic [7:0]          o_filtered,
    output logic                o_frame_end
);

    localparam int OB_DEPTH = 2;
    localparam int OB_PTR_W = 1;
    localparam int OB_CNT_W = 2;

    // Product stage
    logic                   r_b1_valid;
    logic                   r_b1_last;
    c3f_pkg::t_pix          r_prod [c3f_pkg::KERNEL_TAPS];
    c3f_pkg::t_pix          n_prod [c3f_pkg::KERNEL_TAPS];
    logic                   b1_ready;

    // Output buffer
    c3f_pkg::t_pix          r_ob_data [OB_DEPTH];
    logic [OB_DEPTH-1:0]    r_ob_last;
    logic [OB_PTR_W-1:0]    r_ob_wptr;
    logic [OB_PTR_W-1:0]    r_ob_rptr;
    logic [OB_CNT_W-1:0]    r_ob_count;
    logic                   ob_take;
    logic                   ob_pop;
    c3f_pkg::t_pix          sum;

    assign ob_take  = r_b1_valid && (r_ob_count != OB_CNT_W'(OB_DEPTH));
    assign b1_ready = !r_b1_valid || ob_take;
    assign o_q_pop  = !i_q_empty && b1_ready;
    assign ob_pop   = i_pop && (r_ob_count != '0);

    // One multiplier lane per tap, low byte kept
    always_comb begin
        logic [15:0] wide;
        for (int dr = 0; dr < c3f_pkg::KERNEL_DIM; dr++) begin
            for (int dc = 0; dc < c3f_pkg::KERNEL_DIM; dc++) begin
                wide = {8'd0, i_item.window[dc][dr]}
                       * {8'd0, i_kernel[c3f_pkg::KERNEL_DIM * dr + dc]};
                n_prod[c3f_pkg::KERNEL_DIM * dr + dc] = wide[7:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_prod    <= n_prod;
            r_b1_last <= i_item.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b1_valid <= 1'b0;
        end else if (o_q_pop) begin
            r_b1_valid <= 1'b1;
        end else if (ob_take) begin
            r_b1_valid <= 1'b0;
        end
    end

    // Byte-wide sum wraps modulo 256 by itself
    always_comb begin
        sum = '0;
        for (int k = 0; k < c3f_pkg::KERNEL_TAPS; k++) begin
            sum = sum + r_prod[k];
        end
    end

    // Output buffer storage
    always_ff @(posedge i_clk) begin
        if (ob_take) begin
            r_ob_data[r_ob_wptr] <= sum;
            r_ob_last[r_ob_wptr] <= r_b1_last;
        end
    end

    // Output buffer pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ob_wptr  <= '0;
            r_ob_rptr  <= '0;
            r_ob_count <= '0;
        end else begin
            if (ob_take) begin
                r_ob_wptr <= r_ob_wptr + 1'b1;
            end
            if (ob_pop) begin
                r_ob_rptr <= r_ob_rptr + 1'b1;
            end
            if (ob_take && !ob_pop) begin
                r_ob_count <= r_ob_count + 1'b1;
            end else if (!ob_take && ob_pop) begin
                r_ob_count <= r_ob_count - 1'b1;
            end
        end
    end

    assign o_empty     = (r_ob_count == '0);
    assign o_filtered  = r_ob_data[r_ob_rptr];
    assign o_frame_end = r_ob_last[r_ob_rptr];

endmodule

// ===== design/conv3x3_mod256_filter_core.sv =====
`timescale 1ns / 1ps
// conv3x3_mod256_filter_core: top level of the zero-padded 3x3 filter.
// Depends on c3f_pkg, c3f_front, c3f_queue and c3f_back.

// Zero-padded 3x3 convolution of an 8-bit raster image, modulo 256. The core
// takes one beat (pixel or drain) per clock while not full and returns results
// in raster order at up to one per clock. A result leaves the front in the cycle
// after the beat that completes its neighborhood, then passes the window queue,
// the product register and the output buffer to the result ports. The input side
// reports full only when the four-entry window queue between front and back
// could not take every beat already in flight. The line store is four row banks
// of MAX_WIDTH bytes with two read ports; no clearing pass is needed after reset.
// After the final pixel of a frame, drain beats release the remaining results;
// frame_end marks the last one. Writing frame_width or frame_height restarts the
// frame; configuration should be written only while the core is idle.

module conv3x3_mod256_filter_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Configuration write port
    input  logic                            i_cfg_we,
    input  logic [c3f_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [c3f_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    // Input queue side
    input  logic                            push,
    output logic                            full,
    input  logic                            i_command,
    input  logic [7:0]                      i_pixel,
    // Result queue side
    output logic                            empty,
    input  logic                            pop,
    output logic [7:0]                      o_filtered,
    output logic                            o_frame_end
);

    c3f_pkg::t_geom                 r_geom;
    c3f_pkg::t_kernel               r_kernel;
    logic                           restart;
    logic [c3f_pkg::CFG_GEOM_W-1:0] raw_geom;
    logic [c3f_pkg::W_W-1:0]        n_width;
    logic [c3f_pkg::H_W-1:0]        n_height;

    logic                           q_push;
    c3f_pkg::t_item                 q_in_item;
    logic                           q_pop;
    c3f_pkg::t_item                 q_out_item;
    logic                           q_empty;
    logic [c3f_pkg::QCNT_W-1:0]     q_count;

    // Clamp geometry writes into the supported range
    always_comb begin
        raw_geom = i_cfg_data[c3f_pkg::CFG_GEOM_W-1:0];
        if (raw_geom == '0) begin
            n_width  = c3f_pkg::W_W'(1);
            n_height = c3f_pkg::H_W'(1);
        end else begin
            n_width  = (32'(raw_geom) > c3f_pkg::MAX_WIDTH)
                       ? c3f_pkg::W_W'(c3f_pkg::MAX_WIDTH) : c3f_pkg::W_W'(raw_geom);
            n_height = (32'(raw_geom) > c3f_pkg::MAX_HEIGHT)
                       ? c3f_pkg::H_W'(c3f_pkg::MAX_HEIGHT) : c3f_pkg::H_W'(raw_geom);
        end
    end

    assign restart = i_cfg_we
        && ((c3f_pkg::t_cfg_reg'(i_cfg_index) == c3f_pkg::REG_FRAME_WIDTH)
         || (c3f_pkg::t_cfg_reg'(i_cfg_index) == c3f_pkg::REG_FRAME_HEIGHT));

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_geom.width  <= (c3f_pkg::FRAME_W_RESET > c3f_pkg::MAX_WIDTH)
                             ? c3f_pkg::W_W'(c3f_pkg::MAX_WIDTH)
                             : c3f_pkg::W_W'(c3f_pkg::FRAME_W_RESET);
            r_geom.height <= (c3f_pkg::FRAME_H_RESET > c3f_pkg::MAX_HEIGHT)
                             ? c3f_pkg::H_W'(c3f_pkg::MAX_HEIGHT)
                             : c3f_pkg::H_W'(c3f_pkg::FRAME_H_RESET);
            r_kernel      <= '0;
        end else if (i_cfg_we) begin
            case (c3f_pkg::t_cfg_reg'(i_cfg_index))
                c3f_pkg::REG_FRAME_WIDTH: begin
                    r_geom.width <= n_width;
                end
                c3f_pkg::REG_FRAME_HEIGHT: begin
                    r_geom.height <= n_height;
                end
                c3f_pkg::REG_KERNEL_LOW: begin
                    r_kernel[7:0] <= i_cfg_data;
                end
                c3f_pkg::REG_KERNEL_NINTH: begin
                    r_kernel[8] <= i_cfg_data[7:0];
                end
                default: begin
                    r_kernel <= r_kernel;
                end
            endcase
        end
    end

    // Front: counters, line store, window build
    c3f_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_restart  (restart),
        .i_geom     (r_geom),
        .i_push     (push),
        .i_command  (i_command),
        .i_pixel    (i_pixel),
        .i_q_count  (q_count),
        .o_full     (full),
        .o_q_push   (q_push),
        .o_q_item   (q_in_item)
    );

    // Window queue
    c3f_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (q_push),
        .i_item     (q_in_item),
        .i_pop      (q_pop),
        .o_item     (q_out_item),
        .o_empty    (q_empty),
        .o_count    (q_count)
    );

    // Back: multiply, sum, output buffer
    c3f_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (q_out_item),
        .i_q_empty   (q_empty),
        .o_q_pop     (q_pop),
        .i_kernel    (r_kernel),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_filtered  (o_filtered),
        .o_frame_end (o_frame_end)
    );

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// testbench: self-checking bench for conv3x3_mod256_filter_core, with directed and random beats.
// Depends on c3f_pkg and the RTL of the core; results are checked against a local predictor.

module testbench;
    import c3f_pkg::*;

    // Directed plan: a row either writes a register or sends one beat
    typedef enum logic {
        ROW_CFG,
        ROW_BEAT
    } row_kind_e;

    typedef enum logic [1:0] {
        CHK_MODEL,
        CHK_NONE,
        CHK_FIXED
    } row_chk_e;

    typedef struct packed {
        row_kind_e   kind;
        t_cfg_reg    sel;
        logic [63:0] data;
        t_cmd        cmd;
        t_pix        pix;
        row_chk_e    chk;
        t_pix        want_pix;
        logic        want_end;
    } plan_row_t;

    typedef struct packed {
        t_pix value;
        logic last;
    } result_t;

    localparam int PLAN_ROWS    = 34;
    localparam int RANDOM_BEATS = 1150;
    localparam int SETTLE       = 8;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  push;
    logic                  full;
    logic                  i_command;
    logic [7:0]            i_pixel;
    logic                  empty;
    logic                  pop;
    logic [7:0]            o_filtered;
    logic                  o_frame_end;

    conv3x3_mod256_filter_core u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .push        (push),
        .full        (full),
        .i_command   (i_command),
        .i_pixel     (i_pixel),
        .empty       (empty),
        .pop         (pop),
        .o_filtered  (o_filtered),
        .o_frame_end (o_frame_end)
    );

    always #4 i_clk = ~i_clk;

    // Predictor state: raw geometry, taps, four row banks, input and output positions
    logic [CFG_GEOM_W-1:0] geom_w_raw;
    logic [CFG_GEOM_W-1:0] geom_h_raw;
    t_pix                  taps [KERNEL_TAPS];
    t_pix                  line_bank [LINE_ROWS][MAX_WIDTH];
    int unsigned           fill_row, fill_col, emit_row, emit_col;

    result_t     filtered_due [$];
    int          errors;
    int unsigned useful_beats;
    bit          frame_closed;
    bit          send_calm;

    function automatic int unsigned clamp_dim(logic [CFG_GEOM_W-1:0] raw, int unsigned lim);
        if (raw == 0) return 1;
        if (raw > lim) return lim;
        return raw;
    endfunction

    function automatic void restart_frame();
        fill_row = 0;
        fill_col = 0;
        emit_row = 0;
        emit_col = 0;
    endfunction

    // Register write as the core sees it
    function automatic void apply_reg(t_cfg_reg sel, logic [63:0] data);
        case (sel)
            REG_FRAME_WIDTH: begin
                geom_w_raw = data[CFG_GEOM_W-1:0];
                restart_frame();
            end
            REG_FRAME_HEIGHT: begin
                geom_h_raw = data[CFG_GEOM_W-1:0];
                restart_frame();
            end
            REG_KERNEL_LOW: begin
                for (int k = 0; k < 8; k++) taps[k] = data[8*k +: 8];
            end
            REG_KERNEL_NINTH: taps[8] = data[7:0];
            default: ;
        endcase
    endfunction

    // One accepted beat: store the pixel, then emit the next result if its window is complete
    function automatic void convolve_beat(input t_cmd cmd, input t_pix pix,
                                          output bit got, output result_t res);
        int unsigned w, h, ri, rj, r, c;
        bit          stored;
        bit          ready;
        t_pix        acc;
        w      = clamp_dim(geom_w_raw, MAX_WIDTH);
        h      = clamp_dim(geom_h_raw, MAX_HEIGHT);
        got    = 1'b0;
        res    = '0;
        stored = 1'b0;
        if (cmd == CMD_PIXEL && fill_row < h && fill_col < w) begin
            line_bank[fill_row % LINE_ROWS][fill_col] = pix;
            stored = 1'b1;
            fill_col++;
            if (fill_col >= w) begin
                fill_col = 0;
                fill_row++;
            end
        end
        if (emit_row >= h || emit_col >= w) begin
            restart_frame();
            useful_beats += stored;
            return;
        end
        // bottom-right in-frame neighbor must have arrived
        ri = (emit_row + 1 < h) ? emit_row + 1 : h - 1;
        rj = (emit_col + 1 < w) ? emit_col + 1 : w - 1;
        ready = (fill_row >= h) || (ri < fill_row) || (ri == fill_row && rj < fill_col);
        if (!ready) begin
            useful_beats += stored;
            return;
        end
        acc = '0;
        for (int dr = 0; dr < KERNEL_DIM; dr++) begin
            for (int dc = 0; dc < KERNEL_DIM; dc++) begin
                r = emit_row + dr;
                c = emit_col + dc;
                if (r >= 1 && r <= h && c >= 1 && c <= w)
                    acc += line_bank[(r - 1) % LINE_ROWS][c - 1] * taps[KERNEL_DIM*dr + dc];
            end
        end
        res.value = acc;
        res.last  = (emit_row == h - 1) && (emit_col == w - 1);
        got       = 1'b1;
        useful_beats++;
        if (res.last) begin
            frame_closed = 1'b1;
            restart_frame();
        end else begin
            emit_col++;
            if (emit_col >= w) begin
                emit_col = 0;
                emit_row++;
            end
        end
    endfunction

    // Send one beat after a random gap; predict once it is taken
    task automatic send_beat(t_cmd cmd, t_pix pix, row_chk_e chk, t_pix want_pix,
                             logic want_end);
        int      gap;
        bit      got;
        result_t res;
        gap = send_calm ? 0 : $urandom_range(0, 7);
        @(negedge i_clk);
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        push      <= 1'b1;
        i_command <= cmd;
        i_pixel   <= pix;
        do @(posedge i_clk); while (full);
        convolve_beat(cmd, pix, got, res);
        case (chk)
            CHK_MODEL: if (got) filtered_due.push_back(res);
            CHK_FIXED: filtered_due.push_back('{value: want_pix, last: want_end});
            default: ;
        endcase
    endtask

    // Hold off input until every predicted result is out, then let the pipeline settle
    task automatic wait_drained();
        @(negedge i_clk);
        push <= 1'b0;
        while (filtered_due.size() != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic write_reg(t_cfg_reg sel, logic [63:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= sel;
        i_cfg_data  <= data;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        apply_reg(sel, data);
    endtask

    // Geometry with junk above the field bits
    task automatic set_geometry(logic [CFG_GEOM_W-1:0] w, logic [CFG_GEOM_W-1:0] h);
        logic [63:0] d;
        d = {$urandom, $urandom};
        d[CFG_GEOM_W-1:0] = w;
        write_reg(REG_FRAME_WIDTH, d);
        d = {$urandom, $urandom};
        d[CFG_GEOM_W-1:0] = h;
        write_reg(REG_FRAME_HEIGHT, d);
    endtask

    task automatic load_kernel();
        logic [63:0] lo;
        logic [63:0] ninth;
        case ($urandom_range(0, 7))
            0: lo = '0;
            1: lo = '1;
            default: lo = {$urandom, $urandom};
        endcase
        case ($urandom_range(0, 7))
            0: ninth = '0;
            1: ninth = 64'hFF;
            default: ninth = {$urandom, $urandom};
        endcase
        write_reg(REG_KERNEL_LOW, lo);
        write_reg(REG_KERNEL_NINTH, ninth);
    endtask

    // One frame of pixels with stray drains, then drain until frame_end is predicted
    task automatic run_frame(input bit allow_breaks, output bit done);
        int unsigned npix, stop_at, twist_at;
        npix     = clamp_dim(geom_w_raw, MAX_WIDTH) * clamp_dim(geom_h_raw, MAX_HEIGHT);
        stop_at  = npix;
        twist_at = npix;
        if (allow_breaks && $urandom_range(0, 9) == 0) stop_at = $urandom_range(0, npix - 1);
        if (allow_breaks && $urandom_range(0, 5) == 0) twist_at = $urandom_range(0, npix - 1);
        frame_closed = 1'b0;
        done         = 1'b0;
        for (int unsigned i = 0; i < stop_at; i++) begin
            // kernel change in the middle of a frame
            if (i == twist_at) begin
                wait_drained();
                load_kernel();
            end
            if ($urandom_range(0, 99) == 0) wait_drained();
            while ($urandom_range(0, 9) == 0)
                send_beat(CMD_DRAIN, t_pix'($urandom), CHK_MODEL, '0, 1'b0);
            send_beat(CMD_PIXEL, t_pix'($urandom), CHK_MODEL, '0, 1'b0);
        end
        if (stop_at < npix) return;
        // pixels past the frame's end act as drains
        while (!frame_closed)
            send_beat(t_cmd'($urandom_range(0, 1)), t_pix'($urandom), CHK_MODEL, '0, 1'b0);
        done = 1'b1;
    endtask

    task automatic random_phase();
        logic [CFG_GEOM_W-1:0] w, h;
        int                    frames;
        bit                    done;
        wait_drained();
        case ($urandom_range(0, 9))
            0:       w = '0;
            1, 2:    w = $urandom_range(7, 16);
            default: w = $urandom_range(1, 6);
        endcase
        case ($urandom_range(0, 9))
            0:       h = '0;
            1, 2:    h = $urandom_range(6, 10);
            default: h = $urandom_range(1, 5);
        endcase
        set_geometry(w, h);
        if ($urandom_range(0, 3) != 0) load_kernel();
        send_calm = ($urandom_range(0, 3) == 0);
        frames    = $urandom_range(1, 3);
        for (int f = 0; f < frames; f++) begin
            run_frame(1'b1, done);
            if (!done) break;
        end
    endtask

    // Directed plan: single-pixel frames with readable results, then a checked 3x3 frame
    plan_row_t plan [PLAN_ROWS] = '{
        '{ROW_CFG,  REG_FRAME_WIDTH,  64'd1, CMD_PIXEL, 8'h00, CHK_NONE,  8'h00, 1'b0},
        '{ROW_CFG,  REG_FRAME_HEIGHT, 64'd1, CMD_PIXEL, 8'h00, CHK_NONE,  8'h00, 1'b0},
        '{ROW_CFG,  REG_KERNEL_LOW,   64'h0000_0001_0000_0000,
                                             CMD_PIXEL, 8'h00, CHK_NONE,  8'h00, 1'b0},
        '{ROW_CFG,  REG_KERNEL_NINTH, 64'd0, CMD_PIXEL, 8'h00, CHK_NONE,  8'h00, 1'b0},
        '{ROW_BEAT, REG_FRAME_WIDTH,  64'd0, CMD_PIXEL, 8'hFF, CHK_FIXED, 8'hFF, 1'b1},
        '{ROW_BEAT, REG_FRAME_WIDTH,  64'd0, CMD_PIXEL, 8'h00, CHK_FIXED, 8'h00, 1'b1},
        // drain on an empty frame gives nothing
        '{ROW_BEAT, REG_FRAME_WIDTH,  64'd0, CMD_DRAIN, 8'h5A, CHK_NONE,  8'h00, 1'b0},
        '{ROW_BEAT, REG_FRAME_WIDTH,  64'd0, CMD_PIXEL, 8'h80, CHK_FIXED, 8'h80, 1'b1},
        '{ROW_CFG,  REG_KERNEL_LOW,   '1,    CMD_PIXEL, 8'h00, CHK_NONE,  8'h00, 1'b0},
        '{ROW_CFG,  REG_KERNEL_NINTH, 64'hFF, CMD_PIXEL, 8'h00, CHK_NONE, 8'h00, 1'b0},
        '{ROW_BEAT, REG_FRAME_WIDTH,  64'd0, CMD_PIXEL, 8'h01, CHK_FIXED, 8'hFF, 1'b1},
        '{ROW_BEAT, REG_FRAME_WIDTH,  64'd0, CMD_PIXEL, 8'hFF, CHK_FIXED, 8'h01, 1'b1},
        // zero geometry acts as 1x1, junk above the field is ignored
        '{ROW_CFG,  REG_FRAME_WIDTH,  64'hFFFF_FFFF_FFFF_F800,
                                             CMD_PIXEL, 8'h00, CHK_NONE,  8'h00, 1'b0},
        '{ROW_CFG,  REG_FRAME_HEIGHT, 64'd0, CMD_PIXEL, 8'h00, CHK_NONE,  8'h00, 1'b0},
        '{ROW_BEAT, REG_FRAME_WIDTH,  64'd0, CMD_PIXEL, 8'h02, CHK_FIXED, 8'hFE, 1'b1},
        // 3x3 frame, every tap distinct
        '{ROW_CFG,  REG_FRAME_WIDTH,  64'd3, CMD_PIXEL, 8'h00, CHK_NONE,  8'h00, 1'b0},
        '{ROW_CFG,  REG_FRAME_HEIGHT, 64'd3, CMD_PIXEL, 8'h00, CHK_NONE,  8'h00, 1'b0},
        '{ROW_CFG,  REG_KERNEL_LOW,   64'h0807_0605_0403_0201,
                                             CMD_PIXEL, 8'h00, CHK_NONE,  8'h00, 1'b0},
        '{ROW_CFG,  REG_KERNEL_NINTH, 64'h09, CMD_PIXEL, 8'h00, CHK_NONE, 8'h00, 1'b0},
        '{ROW_BEAT, REG_FRAME_WIDTH,  64'd0, CMD_PIXEL, 8'hFF, CHK_MODEL, 8'h00, 1'b0},
        '{ROW_BEAT, REG_FRAME_WIDTH,  64'd0, CMD_PIXEL, 8'h00, CHK_MODEL, 8'h00, 1'b0},
        '{ROW_BEAT, REG_FRAME_WIDTH,  64'd0, CMD_PIXEL, 8'h7F, CHK_MODEL, 8'h00, 1'b0},
        '{ROW_BEAT, REG_FRAME_WIDTH,  64'd0, CMD_PIXEL, 8'h80, CHK_MODEL, 8'h00, 1'b0},
        '{ROW_BEAT, REG_FRAME_WIDTH,  64'd0, CMD_PIXEL, 8'h01, CHK_MODEL, 8'h00, 1'b0},
        '{ROW_BEAT, REG_FRAME_WIDTH,  64'd0, CMD_PIXEL, 8'h55, CHK_MODEL, 8'h00, 1'b0},
        // drain in mid-frame still releases a ready result
        '{ROW_BEAT, REG_FRAME_WIDTH,  64'd0, CMD_DRAIN, 8'hFF, CHK_MODEL, 8'h00, 1'b0},
        '{ROW_BEAT, REG_FRAME_WIDTH,  64'd0, CMD_PIXEL, 8'hAA, CHK_MODEL, 8'h00, 1'b0},
        '{ROW_BEAT, REG_FRAME_WIDTH,  64'd0, CMD_PIXEL, 8'hFE, CHK_MODEL, 8'h00, 1'b0},
        '{ROW_BEAT, REG_FRAME_WIDTH,  64'd0, CMD_PIXEL, 8'h33, CHK_MODEL, 8'h00, 1'b0},
        // pixel after the frame is complete acts as a drain
        '{ROW_BEAT, REG_FRAME_WIDTH,  64'd0, CMD_PIXEL, 8'hC3, CHK_MODEL, 8'h00, 1'b0},
        '{ROW_BEAT, REG_FRAME_WIDTH,  64'd0, CMD_DRAIN, 8'h00, CHK_MODEL, 8'h00, 1'b0},
        '{ROW_BEAT, REG_FRAME_WIDTH,  64'd0, CMD_DRAIN, 8'h00, CHK_MODEL, 8'h00, 1'b0},
        '{ROW_BEAT, REG_FRAME_WIDTH,  64'd0, CMD_DRAIN, 8'h00, CHK_MODEL, 8'h00, 1'b0},
        // after frame_end: start of the next frame, nothing ready
        '{ROW_BEAT, REG_FRAME_WIDTH,  64'd0, CMD_DRAIN, 8'h00, CHK_MODEL, 8'h00, 1'b0}
    };

    // Stimulus
    initial begin : stimulus
        int unsigned base;
        bit          done;
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_index  = REG_FRAME_WIDTH;
        i_cfg_data   = '0;
        push         = 1'b0;
        i_command    = CMD_PIXEL;
        i_pixel      = '0;
        errors       = 0;
        useful_beats = 0;
        send_calm    = 1'b0;
        frame_closed = 1'b0;
        geom_w_raw   = CFG_GEOM_W'(FRAME_W_RESET);
        geom_h_raw   = CFG_GEOM_W'(FRAME_H_RESET);
        foreach (taps[k]) taps[k] = '0;
        foreach (line_bank[r, c]) line_bank[r][c] = '0;
        restart_frame();
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (plan[n]) begin
            if (plan[n].kind == ROW_CFG) begin
                wait_drained();
                write_reg(plan[n].sel, plan[n].data);
            end else begin
                send_beat(plan[n].cmd, plan[n].pix, plan[n].chk, plan[n].want_pix,
                          plan[n].want_end);
            end
        end

        // widest row, one full frame, on top of the random budget
        wait_drained();
        set_geometry('1, 11'd1);
        load_kernel();
        run_frame(1'b0, done);
        // tallest frame, single column, abandoned after a few dozen rows
        wait_drained();
        set_geometry(11'd1, '1);
        load_kernel();
        repeat (60) send_beat(CMD_PIXEL, t_pix'($urandom), CHK_MODEL, '0, 1'b0);

        base = useful_beats;
        while (useful_beats - base < RANDOM_BEATS) random_phase();

        wait_drained();
        repeat (16) @(posedge i_clk);
        if (errors == 0)
            $display("PASS conv3x3_mod256_filter_core");
        else
            $display("FAIL conv3x3_mod256_filter_core");
        $finish;
    end

    // Result side: random stalls, compare each beat with the oldest prediction
    initial begin : result_side
        int      stall;
        int      taken;
        bit      calm;
        result_t want;
        pop   = 1'b0;
        taken = 0;
        calm  = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            stall = calm ? 0 : $urandom_range(0, 7);
            @(negedge i_clk);
            if (stall > 0) begin
                pop <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            pop <= 1'b1;
            do @(posedge i_clk); while (empty);
            if (filtered_due.size() == 0) begin
                if (errors < 10)
                    $display("unexpected result: filtered %02h frame_end %0b",
                             o_filtered, o_frame_end);
                errors++;
            end else begin
                want = filtered_due.pop_front();
                if (o_filtered !== want.value || o_frame_end !== want.last) begin
                    if (errors < 10)
                        $display("mismatch: filtered exp %02h got %02h, frame_end exp %0b got %0b",
                                 want.value, o_filtered, want.last, o_frame_end);
                    errors++;
                end
            end
            taken++;
            if (taken % 50 == 0) calm = ($urandom_range(0, 3) == 0);
        end
    end

    // Watchdog
    initial begin : watchdog
        #(5_000_000);
        $display("FAIL conv3x3_mod256_filter_core");
        $finish;
    end

endmodule

// ===== conv3x3_mod256_filter_core.f =====
design/c3f_pkg.sv
design/c3f_queue.sv
design/c3f_front.sv
design/c3f_back.sv
design/conv3x3_mod256_filter_core.sv
sim/testbench.sv
